### rtl/rmv_pkg.sv
// Shared constants, codes and structure types for the running statistics block.
// Depends on nothing; every other file refers to it by scoped names.
package rmv_pkg;

   // Field and accumulator widths.
   localparam int SAMPLE_BITS  = 24;
   localparam int COUNT_BITS   = 16;
   localparam int SUM_BITS     = 40;
   localparam int SQ_BITS      = 2 * SAMPLE_BITS;
   localparam int SUMSQ_BITS   = 62;
   localparam int FRAC_BITS    = 8;
   localparam int MEAN_BITS    = 32;
   localparam int VAR_BITS     = 47;

   // The magnitude of the sum needs one bit fewer than the signed sum.
   localparam int MAG_BITS     = SUM_BITS - 1;
   // The shared adder covers count * sum of squares and the squared sum.
   localparam int ALU_BITS     = 2 * MAG_BITS;
   localparam int DIVISOR_BITS = 2 * COUNT_BITS;
   localparam int DQ_BITS      = VAR_BITS;
   localparam int STEP_BITS    = 6;

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

   // Request kinds.
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic        [COUNT_BITS-1:0]  count;
      logic signed [SUM_BITS-1:0]    sum;
      logic        [SUMSQ_BITS-1:0]  sumsq;
      logic signed [SAMPLE_BITS-1:0] minimum;
      logic signed [SAMPLE_BITS-1:0] maximum;
      logic signed [SAMPLE_BITS-1:0] last;
      logic                          dropped;
   } stats_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0] mean;
      logic [VAR_BITS-1:0]  variance;
   } calc_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] a;
      logic [ALU_BITS-1:0] b;
      logic                sub;
   } alu_op_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] sum;
      logic                carry;
   } alu_res_type;

endpackage

### rtl/rmv_intf.sv
// Valid/ready channel interfaces for requests and responses of the statistics block.
// Depends on rmv_pkg for the field widths.
interface rmv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   kind;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink (input valid, input kind, input sample, output ready);
endinterface

interface rmv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [rmv_pkg::COUNT_BITS-1:0]  sample_count;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] minimum;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] maximum;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] last_sample;
   logic signed [rmv_pkg::MEAN_BITS-1:0]   mean;
   logic        [rmv_pkg::VAR_BITS-1:0]    variance;
   logic                                   stats_valid;
   logic                                   variance_valid;
   logic                                   dropped;

   modport source (output valid, output sample_count, output minimum, output maximum,
                   output last_sample, output mean, output variance, output stats_valid,
                   output variance_valid, output dropped, input ready);
   modport sink (input valid, input sample_count, input minimum, input maximum,
                 input last_sample, input mean, input variance, input stats_valid,
                 input variance_valid, input dropped, output ready);
endinterface

### rtl/rmv_alu.sv
// Shared adder/subtractor of the sequencer (all but the divisor product).
// Depends on rmv_pkg for the operand and result structures.
module rmv_alu (
   input  rmv_pkg::alu_op_type  op,
   output rmv_pkg::alu_res_type res
);

   logic [rmv_pkg::ALU_BITS:0] wide_sum;
   logic [rmv_pkg::ALU_BITS-1:0] b_operand;

   // Subtraction adds the inverted operand plus one; carry out means a >= b.
   assign b_operand = op.sub ? ~op.b : op.b;
   assign wide_sum  = {1'b0, op.a} + {1'b0, b_operand} + (rmv_pkg::ALU_BITS + 1)'(op.sub);

   assign res.sum   = wide_sum[rmv_pkg::ALU_BITS-1:0];
   assign res.carry = wide_sum[rmv_pkg::ALU_BITS];

endmodule

### rtl/rmv_stats.sv
// Accumulator registers: count, sum, sum of squares, minimum, maximum and last sample.
// Depends on rmv_pkg; a request is squared and registered first, then applied in the update.
module rmv_stats (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  rmv_pkg::cmd_type   cmd,
   output rmv_pkg::stats_type stats,
   output logic               done
);

   logic [rmv_pkg::SAMPLE_BITS-1:0]        raw;
   logic [rmv_pkg::SAMPLE_BITS-1:0]        mag;
   logic [rmv_pkg::SQ_BITS-1:0]            sq_in;

   logic                                   kind_ff;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [rmv_pkg::SQ_BITS-1:0]            sq_ff;
   logic                                   apply_ff;
   logic                                   done_ff;

   logic [rmv_pkg::COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [rmv_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [rmv_pkg::SUMSQ_BITS-1:0]         sumsq_ff, sumsq_in;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [rmv_pkg::SAMPLE_BITS-1:0] last_ff, last_in;
   logic                                   dropped_ff, dropped_in;

   // Magnitude and square of the incoming sample, registered before the update.
   assign raw   = cmd.sample;
   assign mag   = raw[rmv_pkg::SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign sq_in = rmv_pkg::SQ_BITS'(mag) * rmv_pkg::SQ_BITS'(mag);

   always_ff @(posedge clock) begin
      if (go) begin
         kind_ff   <= cmd.kind;
         sample_ff <= cmd.sample;
         sq_ff     <= sq_in;
      end
   end

   // Update of the statistics: a clear wins, then a full count drops the sample.
   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      sumsq_in   = sumsq_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      last_in    = last_ff;
      dropped_in = dropped_ff;
      if (apply_ff) begin
         dropped_in = 1'b0;
         priority if (kind_ff == rmv_pkg::KIND_CLEAR) begin
            count_in = '0;
            sum_in   = '0;
            sumsq_in = '0;
            min_in   = '0;
            max_in   = '0;
            last_in  = '0;
         end else if (count_ff == rmv_pkg::COUNT_FULL) begin
            dropped_in = 1'b1;
         end else begin
            // The first sample after a clear sets both extremes.
            if (count_ff == '0 || sample_ff < min_ff) begin
               min_in = sample_ff;
            end
            if (count_ff == '0 || sample_ff > max_ff) begin
               max_in = sample_ff;
            end
            sum_in   = sum_ff + {{(rmv_pkg::SUM_BITS - rmv_pkg::SAMPLE_BITS)
                                   {sample_ff[rmv_pkg::SAMPLE_BITS-1]}}, sample_ff};
            sumsq_in = sumsq_ff + rmv_pkg::SUMSQ_BITS'(sq_ff);
            last_in  = sample_ff;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apply_ff   <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
         sum_ff     <= '0;
         sumsq_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         last_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         apply_ff   <= go;
         done_ff    <= apply_ff;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         sumsq_ff   <= sumsq_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         last_ff    <= last_in;
         dropped_ff <= dropped_in;
      end
   end

   assign stats.count   = count_ff;
   assign stats.sum     = sum_ff;
   assign stats.sumsq   = sumsq_ff;
   assign stats.minimum = min_ff;
   assign stats.maximum = max_ff;
   assign stats.last    = last_ff;
   assign stats.dropped = dropped_ff;
   assign done          = done_ff;

   // A dropped sample is only ever reported against a full count.
   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (done_ff && dropped_ff) |-> (count_ff == rmv_pkg::COUNT_FULL))
      else $error("sample dropped while count was not full");

endmodule

### rtl/rmv_seq.sv
// Sequencer for mean and unbiased variance with one shared adder and a divisor multiply.
// Depends on rmv_pkg and rmv_alu; multiplies by shift-and-add, divides by restoring steps.
module rmv_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rmv_pkg::stats_type stats,
   output rmv_pkg::calc_type  calc,
   output logic               done
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ABS  = 4'd1;
   localparam logic [3:0] S_MDIV = 4'd2;
   localparam logic [3:0] S_MNEG = 4'd3;
   localparam logic [3:0] S_MULA = 4'd4;
   localparam logic [3:0] S_MULB = 4'd5;
   localparam logic [3:0] S_SUB  = 4'd6;
   localparam logic [3:0] S_VDIV = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   localparam int MEAN_DVD_BITS = rmv_pkg::MAG_BITS + rmv_pkg::FRAC_BITS;

   rmv_pkg::alu_op_type  alu_op;
   rmv_pkg::alu_res_type alu_res;

   logic [3:0]                          state_ff, state_in;
   logic                                done_ff, done_in;
   logic [rmv_pkg::STEP_BITS-1:0]       step_ff, step_in;
   logic [rmv_pkg::DIVISOR_BITS-1:0]    rem_ff, rem_in;
   logic [rmv_pkg::DQ_BITS-1:0]         dq_ff, dq_in;
   logic [rmv_pkg::DIVISOR_BITS-1:0]    divisor_ff, divisor_in;
   logic [rmv_pkg::ALU_BITS-1:0]        acc_ff, acc_in;
   logic [rmv_pkg::ALU_BITS-1:0]        prod_ff, prod_in;
   logic [rmv_pkg::MAG_BITS-1:0]        mop_ff, mop_in;
   logic [rmv_pkg::SUMSQ_BITS-1:0]      mcand_ff, mcand_in;
   logic [rmv_pkg::MAG_BITS-1:0]        mag_ff, mag_in;
   logic                                neg_ff, neg_in;
   logic [rmv_pkg::MEAN_BITS-1:0]       mean_ff, mean_in;
   logic [rmv_pkg::VAR_BITS-1:0]        var_ff, var_in;

   logic                                sum_neg;
   logic [rmv_pkg::MAG_BITS-1:0]        mag_now;
   logic [MEAN_DVD_BITS-1:0]            mean_dvd;
   logic [rmv_pkg::ALU_BITS-1:0]        diff;
   logic [rmv_pkg::COUNT_BITS-1:0]      count_less;

   rmv_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign sum_neg    = stats.sum[rmv_pkg::SUM_BITS-1];
   assign mag_now    = sum_neg ? alu_res.sum[rmv_pkg::MAG_BITS-1:0]
                               : stats.sum[rmv_pkg::MAG_BITS-1:0];
   assign mean_dvd   = {mag_now, {rmv_pkg::FRAC_BITS{1'b0}}};
   assign diff       = alu_res.carry ? alu_res.sum : '0;
   assign count_less = stats.count - 1'b1;

   // Operand selection for the shared adder in each phase.
   always_comb begin
      alu_op.a   = '0;
      alu_op.b   = '0;
      alu_op.sub = 1'b0;
      unique case (state_ff)
         S_ABS: begin
            alu_op.b   = {{(rmv_pkg::ALU_BITS - rmv_pkg::SUM_BITS){sum_neg}}, stats.sum};
            alu_op.sub = 1'b1;
         end
         S_MDIV, S_VDIV: begin
            alu_op.a   = rmv_pkg::ALU_BITS'({rem_ff, dq_ff[rmv_pkg::DQ_BITS-1]});
            alu_op.b   = rmv_pkg::ALU_BITS'(divisor_ff);
            alu_op.sub = 1'b1;
         end
         S_MNEG: begin
            alu_op.b   = rmv_pkg::ALU_BITS'(dq_ff[rmv_pkg::MEAN_BITS-1:0]);
            alu_op.sub = 1'b1;
         end
         S_MULA, S_MULB: begin
            alu_op.a = {acc_ff[rmv_pkg::ALU_BITS-2:0], 1'b0};
            alu_op.b = mop_ff[rmv_pkg::MAG_BITS-1] ? rmv_pkg::ALU_BITS'(mcand_ff) : '0;
         end
         S_SUB: begin
            alu_op.a   = prod_ff;
            alu_op.b   = acc_ff;
            alu_op.sub = 1'b1;
         end
         default: begin
            alu_op.sub = 1'b0;
         end
      endcase
   end

   // Phase sequencing and datapath register updates.
   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      mop_in     = mop_ff;
      mcand_in   = mcand_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      mean_in    = mean_ff;
      var_in     = var_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mean_in  = '0;
               var_in   = '0;
               state_in = (stats.count == '0) ? S_DONE : S_ABS;
            end
         end
         S_ABS: begin
            // Magnitude of the sum, then load the mean division (quotient fits 32 bits).
            mag_in     = mag_now;
            neg_in     = sum_neg;
            rem_in     = rmv_pkg::DIVISOR_BITS'(mean_dvd[MEAN_DVD_BITS-1:rmv_pkg::MEAN_BITS]);
            dq_in      = {mean_dvd[rmv_pkg::MEAN_BITS-1:0],
                          {(rmv_pkg::DQ_BITS - rmv_pkg::MEAN_BITS){1'b0}}};
            divisor_in = rmv_pkg::DIVISOR_BITS'(stats.count);
            step_in    = rmv_pkg::STEP_BITS'(rmv_pkg::MEAN_BITS - 1);
            state_in   = S_MDIV;
         end
         S_MDIV, S_VDIV: begin
            // One restoring step: quotient bits enter at the bottom of dq.
            rem_in  = alu_res.carry ? alu_res.sum[rmv_pkg::DIVISOR_BITS-1:0]
                                    : {rem_ff[rmv_pkg::DIVISOR_BITS-2:0],
                                       dq_ff[rmv_pkg::DQ_BITS-1]};
            dq_in   = {dq_ff[rmv_pkg::DQ_BITS-2:0], alu_res.carry};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (state_ff == S_VDIV) begin
                  var_in   = dq_in;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MNEG;
               end
            end
         end
         S_MNEG: begin
            mean_in = neg_ff ? alu_res.sum[rmv_pkg::MEAN_BITS-1:0]
                             : dq_ff[rmv_pkg::MEAN_BITS-1:0];
            if (stats.count[rmv_pkg::COUNT_BITS-1:1] == '0) begin
               state_in = S_DONE;
            end else begin
               // Product count * sum of squares, count taken MSB first.
               acc_in   = '0;
               mop_in   = {stats.count,
                           {(rmv_pkg::MAG_BITS - rmv_pkg::COUNT_BITS){1'b0}}};
               mcand_in = stats.sumsq;
               step_in  = rmv_pkg::STEP_BITS'(rmv_pkg::COUNT_BITS - 1);
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            acc_in  = alu_res.sum;
            mop_in  = {mop_ff[rmv_pkg::MAG_BITS-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               // Keep the first product and square the sum magnitude next.
               prod_in  = alu_res.sum;
               acc_in   = '0;
               mop_in   = mag_ff;
               mcand_in = rmv_pkg::SUMSQ_BITS'(mag_ff);
               step_in  = rmv_pkg::STEP_BITS'(rmv_pkg::MAG_BITS - 1);
               state_in = S_MULB;
            end
         end
         S_MULB: begin
            acc_in  = alu_res.sum;
            mop_in  = {mop_ff[rmv_pkg::MAG_BITS-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            // Numerator count*sumsq - sum^2 over divisor count*(count-1).
            // The variance stays below 2^47 for any 24-bit sample, so the top bits
            // preload the remainder and 47 steps suffice.
            rem_in     = rmv_pkg::DIVISOR_BITS'(diff[rmv_pkg::ALU_BITS-1:rmv_pkg::DQ_BITS]);
            dq_in      = diff[rmv_pkg::DQ_BITS-1:0];
            divisor_in = {{rmv_pkg::COUNT_BITS{1'b0}}, stats.count}
                       * {{rmv_pkg::COUNT_BITS{1'b0}}, count_less};
            step_in    = rmv_pkg::STEP_BITS'(rmv_pkg::DQ_BITS - 1);
            state_in   = S_VDIV;
         end
         S_DONE: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      mop_ff     <= mop_in;
      mcand_ff   <= mcand_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      mean_ff    <= mean_in;
      var_ff     <= var_in;
   end

   assign calc.mean     = mean_ff;
   assign calc.variance = var_ff;
   assign done          = done_ff;

   // A new computation is only started when the sequencer is idle.
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("sequencer started while busy");

   // The partial remainder stays below the divisor throughout a division.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MDIV || state_ff == S_VDIV) |-> (rem_ff < divisor_ff))
      else $error("division remainder reached the divisor");

   // count * sum of squares is never below the squared sum.
   a_numerator_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUB) |-> alu_res.carry)
      else $error("variance numerator negative");

endmodule

### rtl/running_mean_variance_min_max.sv
// Top level of the running mean, variance, minimum and maximum block.
// Depends on rmv_pkg, rmv_intf (rmv_req_if, rmv_rsp_if), rmv_stats and rmv_seq.
//
//   Channel  Direction  Handshake      Contents
//   req_ch   in         valid/ready    kind (add or clear), sample
//   rsp_ch   out        valid/ready    count, min, max, last, mean, variance, flags
//
// Most of the work for a request is the shared adder sequence: 32 mean division steps,
// 16 + 39 multiply steps and 47 variance division steps. With one sample accumulated
// the multiply and variance steps are skipped, and with none all of them are.
// Synchronous reset clears all statistics and both handshakes.
// A finished response waits in its own register, so the next request is taken
// while the response is still stalled; a second result then waits for that register.
module running_mean_variance_min_max (
   input logic       clock,
   input logic       reset,
   rmv_req_if.sink   req_ch,
   rmv_rsp_if.source rsp_ch
);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_STATS = 2'd1;
   localparam logic [1:0] T_CALC  = 2'd2;
   localparam logic [1:0] T_HOLD  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rmv_pkg::stats_type rsp_stats_ff;
   rmv_pkg::calc_type  rsp_calc_ff;

   logic               accept;
   logic               load_rsp;
   logic               calc_start;
   rmv_pkg::cmd_type   cmd;
   rmv_pkg::stats_type stats;
   logic               stats_done;
   rmv_pkg::calc_type  calc;
   logic               calc_done;

   assign req_ch.ready = (state_ff == T_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd.kind     = req_ch.kind;
   assign cmd.sample   = req_ch.sample;
   assign calc_start   = (state_ff == T_STATS) && stats_done;
   assign load_rsp     = (state_ff == T_HOLD) && (!rsp_valid_ff || rsp_ch.ready);

   rmv_stats u_stats (
      .clock (clock),
      .reset (reset),
      .go    (accept),
      .cmd   (cmd),
      .stats (stats),
      .done  (stats_done)
   );

   rmv_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (calc_start),
      .stats (stats),
      .calc  (calc),
      .done  (calc_done)
   );

   // Request flow: update statistics, compute, then hand over to the response register.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_STATS;
            end
         end
         T_STATS: begin
            if (stats_done) begin
               state_in = T_CALC;
            end
         end
         T_CALC: begin
            if (calc_done) begin
               state_in = T_HOLD;
            end
         end
         T_HOLD: begin
            if (load_rsp) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Response valid: cleared when taken, set when a new result is loaded.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_stats_ff <= stats;
         rsp_calc_ff  <= calc;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.sample_count   = rsp_stats_ff.count;
   assign rsp_ch.minimum        = rsp_stats_ff.minimum;
   assign rsp_ch.maximum        = rsp_stats_ff.maximum;
   assign rsp_ch.last_sample    = rsp_stats_ff.last;
   assign rsp_ch.mean           = rsp_calc_ff.mean;
   assign rsp_ch.variance       = rsp_calc_ff.variance;
   assign rsp_ch.stats_valid    = (rsp_stats_ff.count != '0);
   assign rsp_ch.variance_valid = (rsp_stats_ff.count[rmv_pkg::COUNT_BITS-1:1] != '0);
   assign rsp_ch.dropped        = rsp_stats_ff.dropped;

   // The sequencer only finishes while this request is in its compute phase.
   a_calc_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_done |-> (state_ff == T_CALC))
      else $error("computation finished outside the compute phase");

endmodule
